// ===== hdl/lss_pkg.sv =====
// Shared types and constants for the LIFO stack with search.
// No dependencies; every other file of the block but lss_ram imports this package.
package lss_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Operation codes carried in the input tuser
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POPWT,
        S_SCAN,
        S_DONE
    } t_state;

    // One result item
    typedef struct packed {
        t_status                   status;
        logic                      found;
        logic signed [WORD_W-1:0]  top_value;
        logic                      is_empty;
    } t_result;

endpackage

// ===== hdl/lss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lss_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [$clog2(D)-1:0] i_wr_addr,
    input  logic [W-1:0]         i_wr_data,
    input  logic                 i_rd_en,
    input  logic [$clog2(D)-1:0] i_rd_addr,
    output logic [W-1:0]         o_rd_data
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lss_core.sv =====
// Stack sequencer: fill count, top-word register and the shared compare unit
// that walks the store one entry per cycle. Depends on lss_pkg and drives lss_ram.
module lss_core
    import lss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operation item
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [WORD_W-1:0]  i_value,
    // store port
    output logic               o_wr_en,
    output logic [ADDR_W-1:0]  o_wr_addr,
    output logic [WORD_W-1:0]  o_wr_data,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_rd_addr,
    input  logic [WORD_W-1:0]  i_rd_data,
    // result item
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [WORD_W-1:0]   r_top, n_top;
    logic [WORD_W-1:0]   r_word, n_word;
    t_status             r_status, n_status;
    logic                r_found, n_found;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]    r_left, n_left;
    logic                r_pend, n_pend;

    logic                accept;
    logic                hit;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    cnt_m2;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign hit    = r_pend && (i_rd_data == r_word);
    assign cnt_m1 = r_cnt - CNT_W'(1);
    assign cnt_m2 = r_cnt - CNT_W'(2);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_POP:    n_state = (r_cnt > CNT_W'(1)) ? S_POPWT : S_DONE;
                        KIND_SEARCH: n_state = (r_cnt != '0) ? S_SCAN : S_DONE;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_POPWT: n_state = S_DONE;
            S_SCAN: begin
                if (hit || (r_pend && (r_left == '0))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_cnt     = r_cnt;
        n_top     = r_top;
        n_word    = r_word;
        n_status  = r_status;
        n_found   = r_found;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_pend    = r_pend;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cnt[ADDR_W-1:0];
        o_wr_data = i_value;
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_word   = i_value;
                    case (i_kind)
                        KIND_PUSH: begin
                            if (r_cnt == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_top   = i_value;
                                n_cnt   = r_cnt + CNT_W'(1);
                            end
                        end
                        KIND_POP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = cnt_m1;
                                // fetch the word that becomes the new top
                                if (r_cnt > CNT_W'(1)) begin
                                    o_rd_en   = 1'b1;
                                    o_rd_addr = cnt_m2[ADDR_W-1:0];
                                end
                            end
                        end
                        KIND_SEARCH: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_left = r_cnt;
                                n_ptr  = cnt_m1[ADDR_W-1:0];
                                n_pend = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POPWT: n_top = i_rd_data;
            S_SCAN: begin
                // issue the next read from the top down, compare the last one
                if (r_left != '0) begin
                    o_rd_en = 1'b1;
                    n_ptr   = r_ptr - ADDR_W'(1);
                    n_left  = r_left - CNT_W'(1);
                end
                n_pend = (r_left != '0);
                if (hit) begin
                    n_found = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_word   <= n_word;
        r_status <= n_status;
        r_found  <= n_found;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
    end

    // Outputs
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.status    = r_status;
    assign o_res.found     = r_found;
    assign o_res.top_value = (r_cnt == '0) ? '0 : $signed(r_top);
    assign o_res.is_empty  = (r_cnt == '0);

    // Fill count never passes the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("fill count above depth");

    // A push that fits grows the stack by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_PUSH) && (r_cnt != FULL_CNT))
        |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("push did not grow the stack");

    // The scan pointer stays inside the filled part of the store
    a_scan_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (r_left != '0)) |-> (CNT_W'(r_ptr) < r_cnt))
        else $error("scan pointer outside filled entries");

    // The store is only written when an item is taken
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> accept)
        else $error("store write outside accept");

endmodule

// ===== hdl/lifo_stack_with_search.sv =====
// Top level of the LIFO stack with search: stream ports and output register.
// Depends on lss_pkg, lss_core and lss_ram.

// A 64-word stack of signed 32-bit words. Each input item is a push, pop or
// search; each yields one result item with status, search outcome, top word
// and empty flag. The block takes one item at a time. A pop reads the new top
// word back from the store when more than one word is left, and a search
// compares the stored words from the top entry down, since the store's single
// read port feeds one compare per cycle; a match ends the search early, and an
// empty stack is not searched. A result waits in an output register, so the
// next item is taken while it is still unread; a further result that finds
// that register still full holds the block until the waiting one is taken.
// The store needs no clearing pass after reset: the fill count guards every
// read.
module lifo_stack_with_search
    import lss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [1:0] status, [2] found,
                                          // [34:3] top_value, [35] is_empty
);

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    logic               r_out_valid;
    t_result            r_out;

    lss_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    lss_ram #(
        .W (WORD_W),
        .D (STACK_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.is_empty, r_out.top_value,
                              r_out.found, r_out.status};

endmodule

// ===== tb/sv/stack_result_checker.sv =====
// Result checker for the LIFO stack with search: predicts and compares results.
// Depends on lss_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module stack_result_checker
    import lss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,      // [31:0] value
    input  logic [1:0]  i_in_user,      // [1:0] kind
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,     // [1:0] status, [2] found,
                                        // [34:3] top_value, [35] is_empty
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_hits,
    output int          o_empty_hits,
    output int          o_search_hits,
    output int          o_search_misses
);

    // Shadow copy of the stack
    logic [WORD_W-1:0] stack_words [STACK_DEPTH];
    int                stack_fill;
    t_result           expected_results [$];

    int                fail_total;
    int                checked_total;
    int                full_total;
    int                empty_total;
    int                hit_total;
    int                miss_total;

    t_result                  exp_res;
    t_status                  got_status;
    logic                     got_found;
    logic signed [WORD_W-1:0] got_top;
    logic                     got_empty;

    // Apply one operation to the shadow stack and return its result
    function automatic t_result predict_stack_op(input logic [1:0] op,
                                                 input logic [WORD_W-1:0] word);
        t_result res;
        int      idx;
        res.status = ST_OK;
        res.found  = 1'b0;
        case (op)
            KIND_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                    full_total++;
                end else begin
                    stack_words[stack_fill] = word;
                    stack_fill++;
                end
            end
            KIND_POP: begin
                if (stack_fill == 0) begin
                    res.status = ST_EMPTY;
                    empty_total++;
                end else begin
                    stack_fill--;
                end
            end
            KIND_SEARCH: begin
                if (stack_fill == 0) begin
                    res.status = ST_EMPTY;
                    empty_total++;
                end else begin
                    // top entry down; first match is enough
                    for (idx = stack_fill - 1; idx >= 0; idx--) begin
                        if (stack_words[idx] == word) begin
                            res.found = 1'b1;
                            break;
                        end
                    end
                    if (res.found) hit_total++;
                    else miss_total++;
                end
            end
            default: ;  // unused kind leaves the stack alone
        endcase
        res.top_value = (stack_fill > 0) ? stack_words[stack_fill - 1] : '0;
        res.is_empty  = (stack_fill == 0);
        return res;
    endfunction

    // Watch both channels; predict on input, compare on output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_fill = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_stack_op(i_in_user, i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no prediction waiting: data %h", i_out_data);
                    fail_total++;
                end else begin
                    exp_res    = expected_results.pop_front();
                    got_status = t_status'(i_out_data[1:0]);
                    got_found  = i_out_data[2];
                    got_top    = i_out_data[34:3];
                    got_empty  = i_out_data[35];
                    checked_total++;
                    if (got_status != exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, got_status);
                        fail_total++;
                    end
                    if (got_found != exp_res.found) begin
                        $error("found: expected %0d, got %0d", exp_res.found, got_found);
                        fail_total++;
                    end
                    if (got_top != exp_res.top_value) begin
                        $error("top_value: expected %0d, got %0d",
                               $signed(exp_res.top_value), got_top);
                        fail_total++;
                    end
                    if (got_empty != exp_res.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", exp_res.is_empty, got_empty);
                        fail_total++;
                    end
                end
            end
        end
        // publish after the edge so readers see settled values
        o_fail_count    <= fail_total;
        o_pending       <= expected_results.size();
        o_checked       <= checked_total;
        o_full_hits     <= full_total;
        o_empty_hits    <= empty_total;
        o_search_hits   <= hit_total;
        o_search_misses <= miss_total;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for the LIFO stack with search: clock, reset, stimulus, verdict.
// Depends on lss_pkg, lifo_stack_with_search and stack_result_checker.
`timescale 1ns / 1ps

module testbench;
    import lss_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         ITEMS_TOTAL  = 1550;
    localparam int         TAIL_CYCLES  = STACK_DEPTH + 16;
    localparam longint     RUN_LIMIT_NS = 10_000_000;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data  = '0;    // [31:0] value
    logic [1:0]  s_user  = '0;    // [1:0] kind
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;          // [1:0] status, [2] found, [34:3] top_value, [35] is_empty

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;
    int phase_end;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int search_hits;
    int search_misses;

    lifo_stack_with_search i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    stack_result_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (s_valid),
        .i_in_ready      (s_ready),
        .i_in_data       (s_data),
        .i_in_user       (s_user),
        .i_out_valid     (m_valid),
        .i_out_ready     (m_ready),
        .i_out_data      (m_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_hits     (full_hits),
        .o_empty_hits    (empty_hits),
        .o_search_hits   (search_hits),
        .o_search_misses (search_misses)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Result side: random back-pressure
    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hard stop
    initial begin
        #(RUN_LIMIT_NS);
        $display("testbench failed");
        $finish;
    end

    // Half from a small pool so searches hit, plus extremes and full-range words
    function automatic logic [31:0] pick_word();
        logic [31:0] word;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: word = $urandom_range(15);
            5: begin
                case ($urandom_range(3))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7FFF_FFFF;
                    2:       word = 32'hFFFF_FFFF;
                    default: word = 32'h0000_0000;
                endcase
            end
            default: word = $urandom;
        endcase
        return word;
    endfunction

    // Offer one item, with random idle cycles ahead of it, until accepted
    task automatic send_item(input logic [1:0] op, input logic [31:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= word;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        if (op != KIND_UNUSED) items_sent++;
    endtask

    // Hold off until every predicted result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Push until the stack is surely full and a few pushes get dropped
    task automatic fill_burst();
        int pushes;
        pushes = 0;
        while (pushes < STACK_DEPTH + 4) begin
            if ($urandom_range(99) < 80) begin
                send_item(KIND_PUSH, pick_word());
                pushes++;
            end else begin
                send_item(KIND_SEARCH, pick_word());
            end
        end
    endtask

    // Pop until the stack is surely empty, with searches and unused kinds on the way down
    task automatic drain_burst();
        int pops;
        int pick;
        pops = 0;
        while (pops < STACK_DEPTH + 4) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_item(KIND_POP, $urandom);
                pops++;
            end else if (pick < 95) begin
                send_item(KIND_SEARCH, pick_word());
            end else begin
                send_item(KIND_UNUSED, $urandom);
            end
        end
    endtask

    // Free mix of all kinds
    task automatic mixed_burst();
        int pick;
        repeat (40) begin
            pick = $urandom_range(99);
            if (pick < 40)      send_item(KIND_PUSH, pick_word());
            else if (pick < 75) send_item(KIND_POP, $urandom);
            else if (pick < 95) send_item(KIND_SEARCH, pick_word());
            else                send_item(KIND_UNUSED, $urandom);
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, deep/top/missing searches
        src_idle_pct   = 30;
        sink_stall_pct = 54;
        send_item(KIND_SEARCH, 32'h0000_0005);
        send_item(KIND_POP,    32'h0000_0000);
        send_item(KIND_UNUSED, 32'hFFFF_FFFF);
        send_item(KIND_PUSH,   32'h7FFF_FFFF);
        send_item(KIND_PUSH,   32'h8000_0000);
        send_item(KIND_PUSH,   32'h0000_0000);
        send_item(KIND_PUSH,   32'hFFFF_FFFF);
        send_item(KIND_PUSH,   32'h0000_0001);
        send_item(KIND_SEARCH, 32'h8000_0000);
        send_item(KIND_SEARCH, 32'h7FFF_FFFF);
        send_item(KIND_SEARCH, 32'h0000_0001);
        send_item(KIND_SEARCH, 32'h1234_5678);
        send_item(KIND_UNUSED, 32'hA5A5_A5A5);
        send_item(KIND_POP,    32'hFFFF_FFFF);
        send_item(KIND_SEARCH, 32'h0000_0001);
        repeat (4) send_item(KIND_POP, 32'h5A5A_5A5A);
        send_item(KIND_POP,    32'h0000_0000);
        send_item(KIND_PUSH,   32'h5555_AAAA);
        send_item(KIND_POP,    32'h0000_0000);
        wait_drained();

        // random: three idle/stall mixes, each opening with a full fill and drain
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 30; sink_stall_pct = 54; end
                1: begin src_idle_pct = 54; sink_stall_pct = 30; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            phase_end = (phase == 2) ? ITEMS_TOTAL : items_sent + (ITEMS_TOTAL - items_sent) / (3 - phase);
            fill_burst();
            drain_burst();
            while (items_sent < phase_end) begin
                case ($urandom_range(3))
                    0:       fill_burst();
                    1:       drain_burst();
                    default: mixed_burst();
                endcase
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d stack operations over three idle/stall mixes, %0d results checked.",
                 items_sent, checked);
        $display("Full-stack pushes %0d, empty pops/searches %0d, search hits %0d, misses %0d.",
                 full_hits, empty_hits, search_hits, search_misses);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
